### rtl/tpim_pkg.sv
`timescale 1ns / 1ps

package tpim_pkg;

    // largest plane dimension honored; larger settings clamp to it
    localparam int MAX_DIM = 4096;
    // batch wrap, a power of two no larger than the batch field range
    localparam int MAX_BATCH = 256;

    // reflect distance past the far edge skips the edge element itself
    localparam int REFLECT_SKIP = 2;

    // pad modes
    localparam logic [1:0] MODE_CONSTANT = 2'd0;
    localparam logic [1:0] MODE_REFLECT  = 2'd1;
    localparam logic [1:0] MODE_EDGE     = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_PAD_MODE          = 3'd0;
    localparam logic [2:0] REG_PAD_LEFT          = 3'd1;
    localparam logic [2:0] REG_PAD_TOP           = 3'd2;
    localparam logic [2:0] REG_PAD_CHANNEL_BEGIN = 3'd3;
    localparam logic [2:0] REG_IN_WIDTH          = 3'd4;
    localparam logic [2:0] REG_IN_HEIGHT         = 3'd5;
    localparam logic [2:0] REG_IN_CHANNELS       = 3'd6;
    localparam logic [2:0] REG_PAD_VALUE         = 3'd7;

    typedef struct packed {
        logic [7:0]  batch_index;
        logic [12:0] out_channel;
        logic [12:0] out_row;
        logic [12:0] out_col;
    } in_item_t;

    typedef struct packed {
        logic        use_fill;
        logic [31:0] fill_word;
        logic [7:0]  src_batch;
        logic [11:0] src_channel;
        logic [11:0] src_row;
        logic [11:0] src_col;
        logic        map_error;
    } out_item_t;

    typedef struct packed {
        logic        err;
        logic [11:0] src;
    } axis_map_t;

    // zero acts as one, above the limit acts as the limit
    function automatic logic [12:0] eff_dim(logic [12:0] d);
        logic [12:0] r;
        if (d == 13'd0)
            r = 13'd1;
        else if (32'(d) > MAX_DIM)
            r = 13'(MAX_DIM);
        else
            r = d;
        return r;
    endfunction

    // mirror about the edge element without repeating it
    function automatic axis_map_t reflect_axis(logic [12:0] o, logic [11:0] pad,
                                               logic [12:0] n);
        logic signed [14:0] os;
        logic signed [14:0] ps;
        logic signed [14:0] ns;
        logic signed [14:0] r;
        axis_map_t          m;
        os = signed'({2'b00, o});
        ps = signed'({3'b000, pad});
        ns = signed'({2'b00, n});
        if (os < ps)
            r = ps - os;
        else if (os < ps + ns)
            r = os - ps;
        else
            r = ns - 15'(REFLECT_SKIP) - (os - ps - ns);
        m.err = (r < 15'sd0) || (r >= ns);
        m.src = r[11:0];
        return m;
    endfunction

    // clamp to the nearest edge
    function automatic logic [11:0] edge_axis(logic [12:0] o, logic [11:0] pad,
                                              logic [12:0] n);
        logic [13:0] ou;
        logic [13:0] pu;
        logic [13:0] nu;
        logic [13:0] r;
        ou = {1'b0, o};
        pu = {2'b00, pad};
        nu = {1'b0, n};
        if (ou < pu)
            r = 14'd0;
        else if (ou >= pu + nu)
            r = nu - 14'd1;
        else
            r = ou - pu;
        return r[11:0];
    endfunction

endpackage

### rtl/tensor_pad_index_map_top.sv
`timescale 1ns / 1ps
// an item moves from the input register to the result register; a stall can hold it in either
// throughput: one item per cycle unless stalled; single mapping stage between the two registers
// item_stall rises only while both registers hold items and the result side stalls
// reset (rst_n low, asynchronous) empties both registers and returns every
// configuration register to its reset value; cfg_ready is always high

module tensor_pad_index_map_top (
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  tpim_pkg::in_item_t  item,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output tpim_pkg::out_item_t result,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam logic [7:0] BATCH_MASK = 8'(tpim_pkg::MAX_BATCH - 1);

    // configuration registers
    logic [1:0]  pad_mode_reg;
    logic [11:0] pad_left_reg;
    logic [11:0] pad_top_reg;
    logic [11:0] pad_channel_begin_reg;
    logic [12:0] in_width_reg;
    logic [12:0] in_height_reg;
    logic [12:0] in_channels_reg;
    logic [31:0] pad_value_reg;

    // pipeline registers
    tpim_pkg::in_item_t  item_reg;
    logic                item_valid_reg;
    tpim_pkg::out_item_t result_reg;
    logic                result_valid_reg;
    tpim_pkg::out_item_t result_next;

    logic advance;
    logic take_item;

    // mapping working values
    logic [12:0]         nw;
    logic [12:0]         nh;
    logic [12:0]         nc;
    logic [13:0]         c_ext;
    logic [13:0]         h_ext;
    logic [13:0]         w_ext;
    logic [13:0]         pc_ext;
    logic [13:0]         pt_ext;
    logic [13:0]         pl_ext;
    logic                const_fill;
    logic [13:0]         const_ch;
    logic [13:0]         const_row;
    logic [13:0]         const_col;
    tpim_pkg::axis_map_t refl_row;
    tpim_pkg::axis_map_t refl_col;
    logic [11:0]         edge_row;
    logic [11:0]         edge_col;
    logic [11:0]         edge_ch;
    logic                fill;
    logic                err;
    logic [11:0]         sc;
    logic [11:0]         sr;
    logic [11:0]         sw;

    // handshake: result register frees when empty or taken
    assign advance      = !result_valid_reg || !result_stall;
    assign item_stall   = item_valid_reg && !advance;
    assign take_item    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_mode_reg          <= tpim_pkg::MODE_CONSTANT;
            pad_left_reg          <= 12'd0;
            pad_top_reg           <= 12'd0;
            pad_channel_begin_reg <= 12'd0;
            in_width_reg          <= 13'd1;
            in_height_reg         <= 13'd1;
            in_channels_reg       <= 13'd1;
            pad_value_reg         <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tpim_pkg::REG_PAD_MODE:          pad_mode_reg          <= cfg_data[1:0];
                tpim_pkg::REG_PAD_LEFT:          pad_left_reg          <= cfg_data[11:0];
                tpim_pkg::REG_PAD_TOP:           pad_top_reg           <= cfg_data[11:0];
                tpim_pkg::REG_PAD_CHANNEL_BEGIN: pad_channel_begin_reg <= cfg_data[11:0];
                tpim_pkg::REG_IN_WIDTH:          in_width_reg          <= cfg_data[12:0];
                tpim_pkg::REG_IN_HEIGHT:         in_height_reg         <= cfg_data[12:0];
                tpim_pkg::REG_IN_CHANNELS:       in_channels_reg       <= cfg_data[12:0];
                tpim_pkg::REG_PAD_VALUE:         pad_value_reg         <= cfg_data;
                default:                         pad_value_reg         <= pad_value_reg;
            endcase
        end
    end

    // input register valid; an empty input register takes an item even while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (advance || !item_valid_reg)
            item_valid_reg <= take_item;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (take_item)
            item_reg <= item;
    end

    // effective dimensions and widened operands
    always_comb
    begin
        nw     = tpim_pkg::eff_dim(in_width_reg);
        nh     = tpim_pkg::eff_dim(in_height_reg);
        nc     = tpim_pkg::eff_dim(in_channels_reg);
        c_ext  = {1'b0, item_reg.out_channel};
        h_ext  = {1'b0, item_reg.out_row};
        w_ext  = {1'b0, item_reg.out_col};
        pc_ext = {2'b00, pad_channel_begin_reg};
        pt_ext = {2'b00, pad_top_reg};
        pl_ext = {2'b00, pad_left_reg};
    end

    // per-mode coordinate mapping
    always_comb
    begin
        const_fill = (c_ext < pc_ext) || (c_ext >= pc_ext + {1'b0, nc})
                  || (h_ext < pt_ext) || (h_ext >= pt_ext + {1'b0, nh})
                  || (w_ext < pl_ext) || (w_ext >= pl_ext + {1'b0, nw});
        const_ch   = c_ext - pc_ext;
        const_row  = h_ext - pt_ext;
        const_col  = w_ext - pl_ext;
        refl_row   = tpim_pkg::reflect_axis(item_reg.out_row, pad_top_reg, nh);
        refl_col   = tpim_pkg::reflect_axis(item_reg.out_col, pad_left_reg, nw);
        edge_row   = tpim_pkg::edge_axis(item_reg.out_row, pad_top_reg, nh);
        edge_col   = tpim_pkg::edge_axis(item_reg.out_col, pad_left_reg, nw);
        edge_ch    = (item_reg.out_channel >= nc) ? 12'(nc - 13'd1)
                                                  : item_reg.out_channel[11:0];
    end

    // mode select and result formatting
    always_comb
    begin
        fill = 1'b0;
        err  = 1'b0;
        sc   = 12'd0;
        sr   = 12'd0;
        sw   = 12'd0;
        case (pad_mode_reg)
            tpim_pkg::MODE_CONSTANT:
            begin
                fill = const_fill;
                sc   = const_ch[11:0];
                sr   = const_row[11:0];
                sw   = const_col[11:0];
            end
            tpim_pkg::MODE_REFLECT:
            begin
                err = (item_reg.out_channel >= nc) || refl_row.err || refl_col.err;
                sc  = item_reg.out_channel[11:0];
                sr  = refl_row.src;
                sw  = refl_col.src;
            end
            tpim_pkg::MODE_EDGE:
            begin
                sc = edge_ch;
                sr = edge_row;
                sw = edge_col;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase

        result_next = '0;
        if (err)
            result_next.map_error = 1'b1;
        else if (fill)
        begin
            result_next.use_fill  = 1'b1;
            result_next.fill_word = pad_value_reg;
        end
        else
        begin
            result_next.src_batch   = item_reg.batch_index & BATCH_MASK;
            result_next.src_channel = sc;
            result_next.src_row     = sr;
            result_next.src_col     = sw;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= item_valid_reg;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
            result_reg <= result_next;
    end

endmodule

### rtl/tpim_checker.sv
`timescale 1ns / 1ps

module tpim_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input tpim_pkg::out_item_t result
);

    // a stalled result holds its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // fill results carry no source coordinate and no error
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.use_fill |->
            !result.map_error && result.src_batch == 8'd0 && result.src_channel == 12'd0
            && result.src_row == 12'd0 && result.src_col == 12'd0)
        else $error("fill result with source fields");

    // error results carry nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.map_error |->
            !result.use_fill && result.fill_word == 32'd0 && result.src_batch == 8'd0
            && result.src_channel == 12'd0 && result.src_row == 12'd0
            && result.src_col == 12'd0)
        else $error("error result with payload");

    // item side only stalls while a result is waiting and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled with free result side");

    // copy results carry no pad word
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.use_fill |-> result.fill_word == 32'd0)
        else $error("copy result with pad word");

endmodule

bind tensor_pad_index_map_top tpim_checker u_tpim_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    // pad mode code that the block does not define
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 1500;

    // expected coordinate maps and the register copy they are computed from
    class pad_map_tracker;
        logic [1:0]          mode;
        logic [11:0]         left;
        logic [11:0]         top;
        logic [11:0]         chan_begin;
        logic [12:0]         width;
        logic [12:0]         height;
        logic [12:0]         channels;
        logic [31:0]         fill_value;
        tpim_pkg::out_item_t pending_maps[$];
        int                  mismatches;

        function new();
            mode = tpim_pkg::MODE_CONSTANT;
            left = '0;
            top = '0;
            chan_begin = '0;
            width = 13'd1;
            height = 13'd1;
            channels = 13'd1;
            fill_value = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                tpim_pkg::REG_PAD_MODE:          mode = data[1:0];
                tpim_pkg::REG_PAD_LEFT:          left = data[11:0];
                tpim_pkg::REG_PAD_TOP:           top = data[11:0];
                tpim_pkg::REG_PAD_CHANNEL_BEGIN: chan_begin = data[11:0];
                tpim_pkg::REG_IN_WIDTH:          width = data[12:0];
                tpim_pkg::REG_IN_HEIGHT:         height = data[12:0];
                tpim_pkg::REG_IN_CHANNELS:       channels = data[12:0];
                tpim_pkg::REG_PAD_VALUE:         fill_value = data;
                default:                         fill_value = fill_value;
            endcase
        endfunction

        // zero counts as one, anything past the limit as the limit
        static function int eff(logic [12:0] d);
            if (d == 13'd0)
                return 1;
            if (int'(d) > tpim_pkg::MAX_DIM)
                return tpim_pkg::MAX_DIM;
            return int'(d);
        endfunction

        // mirror without repeating the edge; 0 when the mirror leaves the plane
        function bit mirror_axis(int o, int pad, int n, output int src);
            int r;
            if (o < pad)
                r = pad - o;
            else if (o < pad + n)
                r = o - pad;
            else
                r = n - tpim_pkg::REFLECT_SKIP - (o - pad - n);
            src = r;
            return (r >= 0) && (r < n);
        endfunction

        function int clamp_axis(int o, int pad, int n);
            if (o < pad)
                return 0;
            if (o >= pad + n)
                return n - 1;
            return o - pad;
        endfunction

        function tpim_pkg::out_item_t map_coord(tpim_pkg::in_item_t x);
            tpim_pkg::out_item_t r;
            int                  c, h, w;
            int                  nw, nh, nc;
            int                  pl, pt, pc;
            int                  sc, sr, sw;
            bit                  fill, err;
            c = int'(x.out_channel);
            h = int'(x.out_row);
            w = int'(x.out_col);
            nw = eff(width);
            nh = eff(height);
            nc = eff(channels);
            pl = int'(left);
            pt = int'(top);
            pc = int'(chan_begin);
            sc = 0;
            sr = 0;
            sw = 0;
            fill = 1'b0;
            err = 1'b0;
            r = '0;
            case (mode)
                tpim_pkg::MODE_CONSTANT:
                begin
                    if (c < pc || c >= pc + nc || h < pt || h >= pt + nh ||
                        w < pl || w >= pl + nw)
                        fill = 1'b1;
                    else
                    begin
                        sc = c - pc;
                        sr = h - pt;
                        sw = w - pl;
                    end
                end
                tpim_pkg::MODE_REFLECT:
                begin
                    if (c >= nc)
                        err = 1'b1;
                    else
                        sc = c;
                    if (!mirror_axis(h, pt, nh, sr))
                        err = 1'b1;
                    if (!mirror_axis(w, pl, nw, sw))
                        err = 1'b1;
                end
                tpim_pkg::MODE_EDGE:
                begin
                    sc = (c >= nc) ? nc - 1 : c;
                    sr = clamp_axis(h, pt, nh);
                    sw = clamp_axis(w, pl, nw);
                end
                default:
                    err = 1'b1;
            endcase
            if (err)
                r.map_error = 1'b1;
            else if (fill)
            begin
                r.use_fill = 1'b1;
                r.fill_word = fill_value;
            end
            else
            begin
                r.src_batch = x.batch_index;
                r.src_channel = sc[11:0];
                r.src_row = sr[11:0];
                r.src_col = sw[11:0];
            end
            return r;
        endfunction

        function void note_item(tpim_pkg::in_item_t x);
            pending_maps.push_back(map_coord(x));
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(tpim_pkg::out_item_t got);
            tpim_pkg::out_item_t e;
            if (pending_maps.size() == 0)
            begin
                $error("result transfer with no item outstanding");
                mismatches++;
                return;
            end
            e = pending_maps.pop_front();
            compare_field("use_fill", 32'(e.use_fill), 32'(got.use_fill));
            compare_field("fill_word", e.fill_word, got.fill_word);
            compare_field("src_batch", 32'(e.src_batch), 32'(got.src_batch));
            compare_field("src_channel", 32'(e.src_channel), 32'(got.src_channel));
            compare_field("src_row", 32'(e.src_row), 32'(got.src_row));
            compare_field("src_col", 32'(e.src_col), 32'(got.src_col));
            compare_field("map_error", 32'(e.map_error), 32'(got.map_error));
        endfunction

        function int pending();
            return pending_maps.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    tpim_pkg::in_item_t  item;
    logic                result_valid;
    logic                result_stall;
    tpim_pkg::out_item_t result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [31:0]         cfg_data;

    int stall_style = 0;
    int hold_requests = 0;

    pad_map_tracker board = new();

    tensor_pad_index_map_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watch every transfer on the three channels
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            board.note_item(item);
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
        if (rst_n && cfg_valid && cfg_ready)
            board.write_reg(cfg_index, cfg_data);
    end

    // result side stall pattern, with an occasional long hold-off
    initial
    begin
        int holds_done;
        int cyc;
        holds_done = 0;
        cyc = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_requests != holds_done)
            begin
                holds_done++;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                case (stall_style)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= 1'($urandom_range(0, 1));
                    3:       result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ((cyc % 8) < 3);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // offer one item and hold it until the transfer
    task automatic push_item(input tpim_pkg::in_item_t x);
        item_valid <= 1'b1;
        item <= x;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic send_coord(input int b, input int c, input int h, input int w);
        tpim_pkg::in_item_t x;
        x.batch_index = 8'(b);
        x.out_channel = 13'(c);
        x.out_row = 13'(h);
        x.out_col = 13'(w);
        push_item(x);
    endtask

    // stop offering and wait until every map has come back
    task automatic wait_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // register write; valid stays high across back-to-back writes
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_config(input logic [31:0] m, input logic [31:0] pl,
                                input logic [31:0] pt, input logic [31:0] pc,
                                input logic [31:0] nw, input logic [31:0] nh,
                                input logic [31:0] nc, input logic [31:0] val);
        cfg_write(tpim_pkg::REG_PAD_MODE, m);
        cfg_write(tpim_pkg::REG_PAD_LEFT, pl);
        cfg_write(tpim_pkg::REG_PAD_TOP, pt);
        cfg_write(tpim_pkg::REG_PAD_CHANNEL_BEGIN, pc);
        cfg_write(tpim_pkg::REG_IN_WIDTH, nw);
        cfg_write(tpim_pkg::REG_IN_HEIGHT, nh);
        cfg_write(tpim_pkg::REG_IN_CHANNELS, nc);
        cfg_write(tpim_pkg::REG_PAD_VALUE, val);
        cfg_valid <= 1'b0;
    endtask

    // unused upper bits sometimes set, the block must drop them
    function automatic logic [31:0] with_junk(logic [31:0] v, int bits);
        if ($urandom_range(0, 3) == 0)
            return v | ($urandom << bits);
        return v;
    endfunction

    function automatic logic [31:0] pick_mode();
        int r;
        r = $urandom_range(0, 15);
        if (r == 15)
            return 32'(MODE_UNUSED);
        return 32'(r % 3);
    endfunction

    function automatic logic [31:0] pick_pad();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd4095;
        if (r <= 2)
            return 32'($urandom_range(0, 4095));
        return 32'($urandom_range(0, 6));
    endfunction

    function automatic logic [31:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return 32'($urandom_range(4095, 8191));
        if (r == 2)
            return 32'($urandom_range(0, 8191));
        return 32'($urandom_range(1, 12));
    endfunction

    // mostly near the padded region, sometimes anywhere in the field
    function automatic logic [12:0] pick_coord(int pad, int n);
        int lo, hi;
        if ($urandom_range(0, 3) == 0)
            return 13'($urandom);
        lo = pad - n - 2;
        if (lo < 0)
            lo = 0;
        hi = pad + 2 * n + 2;
        if (hi > 8191)
            hi = 8191;
        return 13'($urandom_range(lo, hi));
    endfunction

    function automatic tpim_pkg::in_item_t random_item();
        tpim_pkg::in_item_t x;
        int                 pc;
        pc = (board.mode == tpim_pkg::MODE_CONSTANT) ? int'(board.chan_begin) : 0;
        x.batch_index = 8'($urandom);
        x.out_channel = pick_coord(pc, pad_map_tracker::eff(board.channels));
        x.out_row = pick_coord(int'(board.top), pad_map_tracker::eff(board.height));
        x.out_col = pick_coord(int'(board.left), pad_map_tracker::eff(board.width));
        return x;
    endfunction

    task automatic random_config();
        apply_config(with_junk(pick_mode(), 2),
                     with_junk(pick_pad(), 12), with_junk(pick_pad(), 12),
                     with_junk(pick_pad(), 12),
                     with_junk(pick_dim(), 13), with_junk(pick_dim(), 13),
                     with_junk(pick_dim(), 13), $urandom);
    endtask

    // bursts of items with random gaps, optionally one pause until drained
    task automatic send_phase(input int count, input bit gaps_on, input bit pause_on);
        int sent;
        int burst;
        int gap;
        int pause_at;
        sent = 0;
        pause_at = $urandom_range(1, count);
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < count)
            begin
                push_item(random_item());
                sent++;
                burst--;
                if (pause_on && sent == pause_at)
                    wait_drain();
            end
            if (gaps_on)
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    item_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    initial
    begin
        int phase;
        int total;
        int count;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        stall_style <= 2;
        @(posedge clk);

        // reset settings: one-element planes in constant mode
        send_coord(0, 0, 0, 0);
        send_coord(255, 8191, 8191, 8191);
        wait_drain();

        // constant fill on channels, rows and columns
        apply_config(32'(tpim_pkg::MODE_CONSTANT), 2, 1, 3, 4, 3, 2, 32'hDEADBEEF);
        send_coord(7, 3, 1, 2);
        send_coord(1, 4, 3, 5);
        send_coord(0, 2, 1, 2);
        send_coord(0, 5, 1, 2);
        send_coord(0, 3, 0, 2);
        send_coord(0, 3, 1, 6);
        wait_drain();

        // reflect both sides, mirror past the plane, channel out of range
        apply_config(32'(tpim_pkg::MODE_REFLECT), 3, 2, 0, 4, 3, 2, 0);
        send_coord(9, 0, 0, 0);
        send_coord(9, 1, 6, 8);
        send_coord(0, 0, 2, 10);
        send_coord(0, 2, 2, 3);
        send_coord(0, 0, 7, 3);
        wait_drain();

        // reflect on a one-wide plane, zero width acting as one
        apply_config(32'(tpim_pkg::MODE_REFLECT), 1, 1, 0, 0, 1, 1, 0);
        send_coord(0, 0, 1, 1);
        send_coord(0, 0, 1, 0);
        wait_drain();

        // edge clamp in the corners, width above the limit
        apply_config(32'(tpim_pkg::MODE_EDGE), 2, 2, 0, 8191, 3, 5, 0);
        send_coord(0, 7, 0, 0);
        send_coord(0, 0, 5, 8191);
        send_coord(0, 2, 4, 2);
        wait_drain();

        // undefined mode
        apply_config(32'(MODE_UNUSED), 0, 0, 0, 1, 1, 1, 0);
        send_coord(0, 0, 0, 0);
        wait_drain();

        // largest pads and dimensions
        apply_config(32'(tpim_pkg::MODE_CONSTANT), 4095, 4095, 4095, 4096, 4096, 4096,
                     32'hFFFFFFFF);
        send_coord(255, 8191, 8191, 8191);
        send_coord(0, 4095, 4095, 4095);
        send_coord(128, 8190, 8190, 8190);
        wait_drain();

        // random settings, each followed by a drain
        phase = 0;
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            random_config();
            stall_style <= $urandom_range(0, 4);
            if (phase == 1 || $urandom_range(0, 19) == 0)
                hold_requests <= hold_requests + 1;
            count = $urandom_range(20, 60);
            send_phase(count, $urandom_range(0, 3) != 0,
                       phase == 0 || $urandom_range(0, 7) == 0);
            total += count;
            phase++;
            wait_drain();
        end

        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### tensor_pad_index_map_top.f
rtl/tpim_pkg.sv
rtl/tensor_pad_index_map_top.sv
rtl/tpim_checker.sv
tb/tb.sv
